FILE: hw/rtl/rts_pkg.sv
// Shared types and constants for the RTOS task scheduler.
package rts_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SEM_SLOTS  = 8;

    localparam int TASK_IDX_W  = $clog2(TASK_SLOTS);
    localparam int TASK_CODE_W = $clog2(TASK_SLOTS + 1);
    localparam int SEM_IDX_W   = $clog2(SEM_SLOTS);
    localparam int SEM_CODE_W  = $clog2(SEM_SLOTS + 1);
    localparam int HANDLE_W    = 3;
    localparam int SEM_ID_W    = 3;
    localparam int WORD_W      = 32;

    localparam logic [TASK_CODE_W-1:0] IDLE_CODE = TASK_CODE_W'(TASK_SLOTS);
    localparam logic [WORD_W-1:0]      COUNT_MAX = {1'b0, {(WORD_W-1){1'b1}}};

    typedef logic [TASK_IDX_W-1:0]  task_idx_t;
    typedef logic [TASK_CODE_W-1:0] task_code_t;

    typedef enum logic [2:0] {
        OP_TASK_CREATE = 3'd0,
        OP_SEM_CREATE  = 3'd1,
        OP_WAIT        = 3'd2,
        OP_TRY_WAIT    = 3'd3,
        OP_SIGNAL      = 3'd4,
        OP_DELAY       = 3'd5,
        OP_TICK        = 3'd6,
        OP_SCHEDULE    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_DELAY = 2'd1,
        ST_SEM   = 2'd2
    } task_status_t;

    typedef struct packed {
        logic [WORD_W-1:0] count;
        task_idx_t         waiter;
        logic              has_waiter;
    } sem_entry_t;

    typedef struct packed {
        logic      push;
        task_idx_t push_id;
        logic      pop_rd;
        logic      pop;
    } queue_ctl_t;

endpackage

FILE: hw/rtl/rtos_task_scheduler_unit.sv
// Top level of the RTOS task scheduler.
//
// One command request enters on the input channel (opcode, sem_id,
// initial_count, delay_ticks) when in_valid is high and in_stall low.
// Exactly one result request leaves on the output channel (ok, handle,
// switch_request, current_task, tick_now) under out_valid / out_stall.
// Commands are processed one at a time: in_stall is low only while the
// sequencer is idle. States from accept to result ready:
//   create, wait, try wait, signal, delay: read, exec, done
//   schedule: read, exec, pop read, pop, done
//   tick: read, then tick read and tick write for each created task, then done
// Reads of the task, semaphore and queue memories are registered, and
// the tick walk visits each created task in the task memory in turn.
// A result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls, the finished command after that holds
// until the output register frees.
// Reset clears the counters, queue pointers and the running task (idle);
// memory entries are written by the create commands before any use.
module rtos_task_scheduler_unit
    import rts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             opcode,
    input  logic [SEM_ID_W-1:0]    sem_id,
    input  logic signed [WORD_W-1:0] initial_count,
    input  logic [WORD_W-1:0]      delay_ticks,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   ok,
    output logic [HANDLE_W-1:0]    handle,
    output logic                   switch_request,
    output logic [TASK_CODE_W-1:0] current_task,
    output logic [WORD_W-1:0]      tick_now
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_READ    = 8'b0000_0010,
        S_EXEC    = 8'b0000_0100,
        S_POP_RD  = 8'b0000_1000,
        S_POP     = 8'b0001_0000,
        S_TICK_RD = 8'b0010_0000,
        S_TICK_WR = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [SEM_ID_W-1:0]    sid_reg, sid_next;
    logic [WORD_W-1:0]      init_reg, init_next;
    logic [WORD_W-1:0]      dly_reg, dly_next;
    logic                   ok_reg, ok_next;
    logic [HANDLE_W-1:0]    handle_reg, handle_next;
    logic                   sw_reg, sw_next;
    logic [TASK_CODE_W-1:0] tasks_made_reg, tasks_made_next;
    logic [SEM_CODE_W-1:0]  sems_made_reg, sems_made_next;
    logic [WORD_W-1:0]      tick_reg, tick_next;
    task_code_t             running_reg, running_next;
    logic [TASK_CODE_W-1:0] idx_reg, idx_next;

    logic                   out_valid_reg;
    logic                   out_ok_reg;
    logic [HANDLE_W-1:0]    out_handle_reg;
    logic                   out_sw_reg;
    task_code_t             out_cur_reg;
    logic [WORD_W-1:0]      out_tick_reg;

    task_status_t           status_mem [TASK_SLOTS];
    logic [WORD_W-1:0]      wake_mem   [TASK_SLOTS];
    sem_entry_t             sem_mem    [SEM_SLOTS];

    task_idx_t              task_raddr;
    task_status_t           task_rd_status;
    logic [WORD_W-1:0]      task_rd_wake;
    task_idx_t              task_waddr;
    logic                   status_we;
    task_status_t           status_wdata;
    logic                   wake_we;
    logic [WORD_W-1:0]      wake_wdata;

    logic [SEM_IDX_W-1:0]   sem_raddr;
    sem_entry_t             sem_rd;
    logic [SEM_IDX_W-1:0]   sem_waddr;
    logic                   sem_we;
    sem_entry_t             sem_wdata;

    queue_ctl_t             qctl;
    task_idx_t              q_rd;
    logic                   q_empty;

    logic                   in_fire;
    logic                   out_fire;
    logic                   out_load;
    logic                   cur_valid;
    logic                   sem_ok;
    logic                   sem_pos;
    logic [WORD_W-1:0]      tick_diff;
    task_idx_t              run_idx;

    rts_ready_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (qctl),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign cur_valid = (running_reg != IDLE_CODE);
    assign run_idx   = running_reg[TASK_IDX_W-1:0];
    assign sem_ok    = (SEM_CODE_W'(sid_reg) < sems_made_reg)
                       && (SEM_CODE_W'(sid_reg) < SEM_CODE_W'(SEM_SLOTS));
    assign sem_pos   = (sem_rd.count != '0) && !sem_rd.count[WORD_W-1];
    assign tick_diff = tick_reg - task_rd_wake;

    assign task_raddr = (state_reg == S_TICK_RD) ? idx_reg[TASK_IDX_W-1:0] : run_idx;
    assign sem_raddr  = sid_reg[SEM_IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sid_next        = sid_reg;
        init_next       = init_reg;
        dly_next        = dly_reg;
        ok_next         = ok_reg;
        handle_next     = handle_reg;
        sw_next         = sw_reg;
        tasks_made_next = tasks_made_reg;
        sems_made_next  = sems_made_reg;
        tick_next       = tick_reg;
        running_next    = running_reg;
        idx_next        = idx_reg;

        task_waddr   = run_idx;
        status_we    = 1'b0;
        status_wdata = ST_READY;
        wake_we      = 1'b0;
        wake_wdata   = '0;
        sem_waddr    = sid_reg[SEM_IDX_W-1:0];
        sem_we       = 1'b0;
        sem_wdata    = sem_rd;
        qctl         = '0;
        qctl.push_id = run_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = op_t'(opcode);
                    sid_next    = sem_id;
                    init_next   = initial_count;
                    dly_next    = delay_ticks;
                    ok_next     = 1'b0;
                    handle_next = '0;
                    sw_next     = 1'b0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (op_reg == OP_TICK)
                begin
                    tick_next = tick_reg + 1'b1;
                    ok_next   = 1'b1;
                    sw_next   = 1'b1;
                    idx_next  = '0;
                    state_next = (tasks_made_reg == '0) ? S_DONE : S_TICK_RD;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_TASK_CREATE:
                    begin
                        if (tasks_made_reg < TASK_CODE_W'(TASK_SLOTS))
                        begin
                            task_waddr      = tasks_made_reg[TASK_IDX_W-1:0];
                            status_we       = 1'b1;
                            status_wdata    = ST_READY;
                            wake_we         = 1'b1;
                            wake_wdata      = '0;
                            qctl.push       = 1'b1;
                            qctl.push_id    = tasks_made_reg[TASK_IDX_W-1:0];
                            tasks_made_next = tasks_made_reg + 1'b1;
                            ok_next         = 1'b1;
                            handle_next     = HANDLE_W'(tasks_made_reg);
                        end
                    end
                    OP_SEM_CREATE:
                    begin
                        if (sems_made_reg < SEM_CODE_W'(SEM_SLOTS))
                        begin
                            sem_waddr            = sems_made_reg[SEM_IDX_W-1:0];
                            sem_we               = 1'b1;
                            sem_wdata.count      = init_reg;
                            sem_wdata.waiter     = '0;
                            sem_wdata.has_waiter = 1'b0;
                            sems_made_next       = sems_made_reg + 1'b1;
                            ok_next              = 1'b1;
                            handle_next          = HANDLE_W'(sems_made_reg);
                        end
                    end
                    OP_WAIT:
                    begin
                        if (cur_valid && sem_ok)
                        begin
                            ok_next = 1'b1;
                            sem_we  = 1'b1;
                            if (sem_pos)
                            begin
                                sem_wdata.count = sem_rd.count - 1'b1;
                            end
                            else
                            begin
                                status_we            = 1'b1;
                                status_wdata         = ST_SEM;
                                sem_wdata.waiter     = run_idx;
                                sem_wdata.has_waiter = 1'b1;
                                sw_next              = 1'b1;
                            end
                        end
                    end
                    OP_TRY_WAIT:
                    begin
                        if (sem_ok && sem_pos)
                        begin
                            sem_we          = 1'b1;
                            sem_wdata.count = sem_rd.count - 1'b1;
                            ok_next         = 1'b1;
                        end
                    end
                    OP_SIGNAL:
                    begin
                        if (sem_ok)
                        begin
                            ok_next = 1'b1;
                            if (sem_rd.has_waiter)
                            begin
                                sem_we               = 1'b1;
                                sem_wdata.has_waiter = 1'b0;
                                task_waddr           = sem_rd.waiter;
                                status_we            = 1'b1;
                                status_wdata         = ST_READY;
                                qctl.push            = 1'b1;
                                qctl.push_id         = sem_rd.waiter;
                                sw_next              = 1'b1;
                            end
                            else if (sem_rd.count != COUNT_MAX)
                            begin
                                sem_we          = 1'b1;
                                sem_wdata.count = sem_rd.count + 1'b1;
                            end
                        end
                    end
                    OP_DELAY:
                    begin
                        if (dly_reg == '0)
                        begin
                            ok_next = 1'b1;
                        end
                        else if (cur_valid)
                        begin
                            status_we    = 1'b1;
                            status_wdata = ST_DELAY;
                            wake_we      = 1'b1;
                            wake_wdata   = tick_reg + dly_reg;
                            ok_next      = 1'b1;
                            sw_next      = 1'b1;
                        end
                    end
                    OP_SCHEDULE:
                    begin
                        ok_next    = 1'b1;
                        qctl.push  = cur_valid && (task_rd_status == ST_READY);
                        state_next = S_POP_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP_RD:
            begin
                qctl.pop_rd = 1'b1;
                state_next  = S_POP;
            end
            S_POP:
            begin
                qctl.pop     = 1'b1;
                running_next = q_empty ? IDLE_CODE : TASK_CODE_W'(q_rd);
                state_next   = S_DONE;
            end
            S_TICK_RD:
            begin
                state_next = S_TICK_WR;
            end
            S_TICK_WR:
            begin
                task_waddr = idx_reg[TASK_IDX_W-1:0];
                if (task_rd_status == ST_DELAY && !tick_diff[WORD_W-1])
                begin
                    status_we    = 1'b1;
                    status_wdata = ST_READY;
                    qctl.push    = 1'b1;
                    qctl.push_id = idx_reg[TASK_IDX_W-1:0];
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == tasks_made_reg) ? S_DONE : S_TICK_RD;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tasks_made_reg <= '0;
            sems_made_reg  <= '0;
            tick_reg       <= '0;
            running_reg    <= IDLE_CODE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tasks_made_reg <= tasks_made_next;
            sems_made_reg  <= sems_made_next;
            tick_reg       <= tick_next;
            running_reg    <= running_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sid_reg    <= sid_next;
        init_reg   <= init_next;
        dly_reg    <= dly_next;
        ok_reg     <= ok_next;
        handle_reg <= handle_next;
        sw_reg     <= sw_next;
        idx_reg    <= idx_next;
        if (out_load)
        begin
            out_ok_reg     <= ok_reg;
            out_handle_reg <= handle_reg;
            out_sw_reg     <= sw_reg;
            out_cur_reg    <= running_reg;
            out_tick_reg   <= tick_reg;
        end
    end

    // task and semaphore memories
    always_ff @(posedge clk)
    begin
        if (status_we)
        begin
            status_mem[task_waddr] <= status_wdata;
        end
        if (wake_we)
        begin
            wake_mem[task_waddr] <= wake_wdata;
        end
        task_rd_status <= status_mem[task_raddr];
        task_rd_wake   <= wake_mem[task_raddr];
        if (sem_we)
        begin
            sem_mem[sem_waddr] <= sem_wdata;
        end
        sem_rd <= sem_mem[sem_raddr];
    end

    assign out_valid      = out_valid_reg;
    assign ok             = out_ok_reg;
    assign handle         = out_handle_reg;
    assign switch_request = out_sw_reg;
    assign current_task   = out_cur_reg;
    assign tick_now       = out_tick_reg;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_READ)
        else $error("accepted request did not start");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result loaded outside done state");

    a_running_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg <= IDLE_CODE)
        else $error("running task out of range");

    a_running_only_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg != $past(running_reg)) |-> $past(state_reg) == S_POP)
        else $error("running task changed outside schedule");

endmodule

FILE: hw/rtl/rts_ready_queue.sv
// Ready queue: ring of task indices in a synchronous memory.
module rts_ready_queue
    import rts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  queue_ctl_t ctl,
    output task_idx_t  rd_data,
    output logic       empty
);

    localparam logic [TASK_CODE_W-1:0] SLOTS = TASK_CODE_W'(TASK_SLOTS);

    task_idx_t              mem [TASK_SLOTS];
    task_idx_t              head_reg, head_next;
    logic [TASK_CODE_W-1:0] fill_reg, fill_next;
    logic [TASK_CODE_W:0]   tail_sum;
    task_idx_t              tail;

    assign empty = (fill_reg == '0);

    always_comb
    begin
        tail_sum = {1'b0, {(TASK_CODE_W-TASK_IDX_W){1'b0}}, head_reg} + {1'b0, fill_reg};
        if (tail_sum >= {1'b0, SLOTS})
        begin
            tail_sum = tail_sum - {1'b0, SLOTS};
        end
        tail = tail_sum[TASK_IDX_W-1:0];
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctl.push && fill_reg < SLOTS)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctl.pop && !empty)
        begin
            fill_next = fill_reg - 1'b1;
            if (head_reg == TASK_IDX_W'(TASK_SLOTS - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && fill_reg < SLOTS)
        begin
            mem[tail] <= ctl.push_id;
        end
        if (ctl.pop_rd)
        begin
            rd_data <= mem[head_reg];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOTS)
        else $error("ready queue overfilled");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.push && ctl.pop))
        else $error("push and pop in one cycle");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.pop && !empty) |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("pop did not shrink queue");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the RTOS task scheduler: directed table, then random commands.
module tb_top;
    import rts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        op_t         op;
        logic [2:0]  sid;
        logic [31:0] init;
        logic [31:0] dly;
        bit          fixed;
        logic        e_ok;
        logic [2:0]  e_handle;
        logic        e_sw;
        logic [3:0]  e_cur;
    } cmd_row_t;

    typedef struct {
        logic        ok;
        logic [2:0]  handle;
        logic        sw;
        logic [3:0]  cur;
        logic [31:0] tick;
    } sched_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] opcode;
    logic [2:0] sem_id;
    logic signed [31:0] initial_count;
    logic [31:0] delay_ticks;
    logic out_valid;
    logic out_stall;
    logic ok;
    logic [2:0] handle;
    logic switch_request;
    logic [3:0] current_task;
    logic [31:0] tick_now;

    rtos_task_scheduler_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .sem_id(sem_id), .initial_count(initial_count),
        .delay_ticks(delay_ticks), .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .handle(handle), .switch_request(switch_request),
        .current_task(current_task), .tick_now(tick_now)
    );

    // scheduler state mirror
    logic [2:0]  rq [8];
    logic [2:0]  rq_head;
    int          rq_fill;
    logic [1:0]  t_status [8];
    logic [31:0] t_wake [8];
    int          n_tasks;
    logic [31:0] s_count [8];
    logic [3:0]  s_waiter [8];
    bit          s_has_waiter [8];
    int          n_sems;
    logic [31:0] ticks;
    logic [3:0]  running;

    sched_result_t expected_results[$];
    bit failed;
    int idle_cycles;
    int out_wait;
    bit done_sending;

    initial
    begin
        clk = 0;
        forever
        begin
            #5 clk = 1;
            #5 clk = 0;
        end
    end

    task automatic push_ready(input logic [2:0] t);
        if (rq_fill < 8)
        begin
            rq[3'(rq_head + rq_fill)] = t;
            rq_fill++;
        end
    endtask

    function automatic bit positive(input logic [31:0] c);
        return c != 0 && !c[31];
    endfunction

    task automatic schedule_model(input op_t op, input logic [2:0] sid,
                                  input logic [31:0] init, input logic [31:0] dly,
                                  output sched_result_t r);
        bit sem_ok;
        bit cur_valid;
        r = '{ok: 0, handle: 0, sw: 0, cur: 0, tick: 0};
        sem_ok = sid < n_sems;
        cur_valid = running < 8;
        case (op)
            OP_TASK_CREATE:
                if (n_tasks < 8)
                begin
                    t_status[n_tasks] = ST_READY;
                    t_wake[n_tasks] = 0;
                    push_ready(3'(n_tasks));
                    r.ok = 1;
                    r.handle = 3'(n_tasks);
                    n_tasks++;
                end
            OP_SEM_CREATE:
                if (n_sems < 8)
                begin
                    s_count[n_sems] = init;
                    s_has_waiter[n_sems] = 0;
                    s_waiter[n_sems] = 0;
                    r.ok = 1;
                    r.handle = 3'(n_sems);
                    n_sems++;
                end
            OP_WAIT:
                if (cur_valid && sem_ok)
                begin
                    r.ok = 1;
                    if (positive(s_count[sid]))
                        s_count[sid] -= 1;
                    else
                    begin
                        t_status[running] = ST_SEM;
                        s_waiter[sid] = running;
                        s_has_waiter[sid] = 1;
                        r.sw = 1;
                    end
                end
            OP_TRY_WAIT:
                if (sem_ok && positive(s_count[sid]))
                begin
                    s_count[sid] -= 1;
                    r.ok = 1;
                end
            OP_SIGNAL:
                if (sem_ok)
                begin
                    r.ok = 1;
                    if (s_has_waiter[sid])
                    begin
                        s_has_waiter[sid] = 0;
                        if (s_waiter[sid] < 8)
                        begin
                            t_status[s_waiter[sid]] = ST_READY;
                            push_ready(s_waiter[sid][2:0]);
                        end
                        r.sw = 1;
                    end
                    else if (s_count[sid] != COUNT_MAX)
                        s_count[sid] += 1;
                end
            OP_DELAY:
                if (dly == 0)
                    r.ok = 1;
                else if (cur_valid)
                begin
                    t_status[running] = ST_DELAY;
                    t_wake[running] = ticks + dly;
                    r.ok = 1;
                    r.sw = 1;
                end
            OP_TICK:
            begin
                logic [31:0] diff;
                ticks += 1;
                for (int i = 0; i < n_tasks; i++)
                begin
                    diff = ticks - t_wake[i];
                    if (t_status[i] == ST_DELAY && !diff[31])
                    begin
                        t_status[i] = ST_READY;
                        push_ready(3'(i));
                    end
                end
                r.ok = 1;
                r.sw = 1;
            end
            default:
            begin
                if (cur_valid && t_status[running] == ST_READY)
                    push_ready(running[2:0]);
                if (rq_fill == 0)
                    running = IDLE_CODE;
                else
                begin
                    running = {1'b0, rq[rq_head]};
                    rq_head = rq_head + 1;
                    rq_fill--;
                end
                r.ok = 1;
            end
        endcase
        r.cur = running;
        r.tick = ticks;
    endtask

    task automatic send(input cmd_row_t c);
        sched_result_t r;
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        opcode <= c.op;
        sem_id <= c.sid;
        initial_count <= c.init;
        delay_ticks <= c.dly;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        schedule_model(c.op, c.sid, c.init, c.dly, r);
        if (c.fixed && (r.ok !== c.e_ok || r.handle !== c.e_handle || r.sw !== c.e_sw
                        || r.cur !== c.e_cur))
        begin
            $display("%0t table row disagrees: expected ok=%0d h=%0d sw=%0d cur=%0d got %0d %0d %0d %0d",
                     $time, c.e_ok, c.e_handle, c.e_sw, c.e_cur, r.ok, r.handle, r.sw, r.cur);
            failed = 1;
        end
        expected_results.push_back(r);
    endtask

    function automatic cmd_row_t row(op_t op, logic [2:0] sid, logic [31:0] init,
                                     logic [31:0] dly);
        return '{op: op, sid: sid, init: init, dly: dly, fixed: 0,
                 e_ok: 0, e_handle: 0, e_sw: 0, e_cur: 0};
    endfunction

    function automatic cmd_row_t fixed_row(op_t op, logic [2:0] sid, logic [31:0] init,
                                           logic [31:0] dly, logic eok, logic [2:0] eh,
                                           logic esw, logic [3:0] ecur);
        return '{op: op, sid: sid, init: init, dly: dly, fixed: 1,
                 e_ok: eok, e_handle: eh, e_sw: esw, e_cur: ecur};
    endfunction

    // receiver with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected request: ok=%0d h=%0d sw=%0d cur=%0d tick=%h",
                             $time, ok, handle, switch_request, current_task, tick_now);
                    failed = 1;
                end
                else
                begin
                    sched_result_t e;
                    e = expected_results.pop_front();
                    if (ok !== e.ok)
                    begin
                        $display("%0t ok expected %0d actual %0d", $time, e.ok, ok);
                        failed = 1;
                    end
                    if (handle !== e.handle)
                    begin
                        $display("%0t handle expected %0d actual %0d", $time, e.handle, handle);
                        failed = 1;
                    end
                    if (switch_request !== e.sw)
                    begin
                        $display("%0t switch_request expected %0d actual %0d",
                                 $time, e.sw, switch_request);
                        failed = 1;
                    end
                    if (current_task !== e.cur)
                    begin
                        $display("%0t current_task expected %0d actual %0d",
                                 $time, e.cur, current_task);
                        failed = 1;
                    end
                    if (tick_now !== e.tick)
                    begin
                        $display("%0t tick_now expected %h actual %h", $time, e.tick, tick_now);
                        failed = 1;
                    end
                end
                out_wait = $urandom_range(0, 11);
            end
            if (out_wait > 0)
            begin
                out_stall <= 1;
                if (out_valid)
                    out_wait--;
            end
            else
                out_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rtos_task_scheduler_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t dir[$];
        int k;
        int r;
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        out_wait = 0;
        opcode = OP_TASK_CREATE;
        sem_id = 0;
        initial_count = 0;
        delay_ticks = 0;
        failed = 0;
        idle_cycles = 0;
        rq_head = 0;
        rq_fill = 0;
        n_tasks = 0;
        n_sems = 0;
        ticks = 0;
        running = IDLE_CODE;
        for (int i = 0; i < 8; i++)
        begin
            rq[i] = 0;
            t_status[i] = ST_READY;
            t_wake[i] = 0;
            s_count[i] = 0;
            s_waiter[i] = 0;
            s_has_waiter[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // idle misuse, missing semaphore, zero delay, empty schedule
        dir.push_back(fixed_row(OP_WAIT, 0, 0, 0, 0, 0, 0, IDLE_CODE));
        dir.push_back(fixed_row(OP_SIGNAL, 7, 0, 0, 0, 0, 0, IDLE_CODE));
        dir.push_back(fixed_row(OP_DELAY, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, IDLE_CODE));
        dir.push_back(fixed_row(OP_DELAY, 0, 0, 0, 1, 0, 0, IDLE_CODE));
        dir.push_back(fixed_row(OP_SCHEDULE, 0, 0, 0, 1, 0, 0, IDLE_CODE));
        dir.push_back(fixed_row(OP_TASK_CREATE, 0, 0, 0, 1, 0, 0, IDLE_CODE));
        dir.push_back(fixed_row(OP_SEM_CREATE, 0, 32'h8000_0000, 0, 1, 0, 0, IDLE_CODE));
        dir.push_back(fixed_row(OP_SEM_CREATE, 0, 32'h7FFF_FFFF, 0, 1, 1, 0, IDLE_CODE));
        dir.push_back(row(OP_TRY_WAIT, 0, 0, 0));
        dir.push_back(row(OP_SIGNAL, 1, 0, 0));
        dir.push_back(row(OP_TRY_WAIT, 1, 0, 0));
        dir.push_back(fixed_row(OP_SCHEDULE, 0, 0, 0, 1, 0, 0, 0));
        dir.push_back(row(OP_WAIT, 0, 0, 0));
        dir.push_back(row(OP_SIGNAL, 0, 0, 0));
        dir.push_back(row(OP_SCHEDULE, 0, 0, 0));
        dir.push_back(row(OP_DELAY, 0, 0, 2));
        dir.push_back(row(OP_TICK, 0, 0, 0));
        dir.push_back(row(OP_TICK, 0, 0, 0));
        dir.push_back(row(OP_SCHEDULE, 0, 0, 0));
        for (int i = 0; i < 7; i++)
            dir.push_back(row(OP_TASK_CREATE, 0, 0, 0));
        dir.push_back(fixed_row(OP_TASK_CREATE, 0, 0, 0, 0, 0, 0, 0));
        foreach (dir[i])
            send(dir[i]);

        for (k = 0; k < 425; k++)
        begin
            cmd_row_t c;
            c = row(op_t'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    $urandom, 32'($urandom_range(0, 4)));
            r = $urandom_range(0, 15);
            if (r == 0)
                c.dly = $urandom;
            else if (r == 1)
                c.dly = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
            if (c.op == OP_TICK || c.op == OP_SCHEDULE)
                if ($urandom_range(0, 2) == 0)
                    c.op = OP_SCHEDULE;
            if (c.op == OP_SEM_CREATE && $urandom_range(0, 1))
                c.init = 32'($urandom_range(0, 3));
            send(c);
        end
        in_valid <= 0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (!failed)
            $display("rtos_task_scheduler_unit: match");
        else
            $display("rtos_task_scheduler_unit: mismatch");
        $finish;
    end
endmodule
